[rtl/cfwa_pkg.sv]
// Package for the conflict-free wave assigner.
// Holds sizing constants, controller state enum and the command/status structs.
// No dependencies.
`default_nettype none

package cfwa_pkg;

  // Sizing of the wave table and the resource masks.
  localparam int unsigned MAX_WAVES    = 16;
  localparam int unsigned MASK_BITS    = 32;
  localparam int unsigned CNT_W        = $clog2(MAX_WAVES + 1);
  localparam int unsigned IDX_W        = (MAX_WAVES > 1) ? $clog2(MAX_WAVES) : 1;

  // Fixed widths of the request and response fields.
  localparam int unsigned READ_MASK_W  = 32;
  localparam int unsigned WRITE_MASK_W = 32;
  localparam int unsigned WAVE_W       = 4;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } cfwa_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture a new request
    logic step;    // advance to the next wave
    logic commit;  // place the task and write the response
  } cfwa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic at_end;  // every open wave has been tested
    logic fits;    // the current wave has no conflict with the task
    logic out_free; // response register can take a new response
  } cfwa_sts_t;

endpackage

`default_nettype wire

[rtl/cfwa_req_if.sv]
// Request channel of the conflict-free wave assigner: one task per request.
// Depends on cfwa_pkg for the field widths.
`default_nettype none

interface cfwa_req_if
  import cfwa_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [READ_MASK_W-1:0]  read_mask;
  logic [WRITE_MASK_W-1:0] write_mask;
  logic                    first_of_set;

  modport source (output valid, read_mask, write_mask, first_of_set, input ready);
  modport sink   (input valid, read_mask, write_mask, first_of_set, output ready);
endinterface

`default_nettype wire

[rtl/cfwa_rsp_if.sv]
// Response channel of the conflict-free wave assigner: one placement per request.
// Depends on cfwa_pkg for the field widths.
`default_nettype none

interface cfwa_rsp_if
  import cfwa_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [WAVE_W-1:0] wave_index;
  logic              opened_wave;
  logic              overflow;

  modport source (output valid, wave_index, opened_wave, overflow, input ready);
  modport sink   (input valid, wave_index, opened_wave, overflow, output ready);
endinterface

`default_nettype wire

[rtl/cfwa_datapath.sv]
// Datapath of the conflict-free wave assigner: wave union tables, open-wave
// count, scan index, conflict test and response register. Depends on cfwa_pkg.
`default_nettype none

module cfwa_datapath
  import cfwa_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire cfwa_cmd_t               cmd_i,
  output cfwa_sts_t                    sts_o,
  input  wire logic [READ_MASK_W-1:0]  read_mask_i,
  input  wire logic [WRITE_MASK_W-1:0] write_mask_i,
  input  wire logic                    first_of_set_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [WAVE_W-1:0]            wave_index_o,
  output logic                         opened_wave_o,
  output logic                         overflow_o
);

  logic [MASK_BITS-1:0] rd_q, wr_q;
  logic [MASK_BITS-1:0] rd_union_q [MAX_WAVES];
  logic [MASK_BITS-1:0] wr_union_q [MAX_WAVES];
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic                 out_valid_q, out_valid_d;
  logic [WAVE_W-1:0]    wave_q;
  logic                 opened_q, ovf_q;

  logic [IDX_W-1:0]     idx_lo;
  logic [MASK_BITS-1:0] ru, wu;
  logic                 conflict, at_end, fits, full;

  // Conflict test of the task against the wave under the scan index.
  assign idx_lo   = idx_q[IDX_W-1:0];
  assign ru       = rd_union_q[idx_lo];
  assign wu       = wr_union_q[idx_lo];
  assign conflict = |((wr_q & wu) | (wr_q & ru) | (rd_q & wu));
  assign at_end   = (idx_q == count_q);
  assign fits     = !at_end && !conflict;
  assign full     = (count_q == CNT_W'(MAX_WAVES));

  assign sts_o.at_end   = at_end;
  assign sts_o.fits     = fits;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // Next values of the count, the scan index and the response valid.
  always_comb begin
    count_d     = count_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.load) begin
      idx_d = '0;
      if (first_of_set_i) begin
        count_d = '0;
      end
    end
    if (cmd_i.step) begin
      idx_d = idx_q + CNT_W'(1);
    end
    if (cmd_i.commit) begin
      out_valid_d = 1'b1;
      if (!fits && !full) begin
        count_d = count_q + CNT_W'(1);
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Captured task masks, limited to the resource width.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rd_q <= MASK_BITS'(read_mask_i);
      wr_q <= MASK_BITS'(write_mask_i);
    end
  end

  // Union tables: merge into a fitting wave or start a new wave at the end.
  // Entries at or above the count are never read, so they need no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (fits) begin
        rd_union_q[idx_lo] <= rd_union_q[idx_lo] | rd_q;
        wr_union_q[idx_lo] <= wr_union_q[idx_lo] | wr_q;
      end else if (!full) begin
        rd_union_q[idx_lo] <= rd_q;
        wr_union_q[idx_lo] <= wr_q;
      end
    end
  end

  // Response register. On overflow the index reads as zero.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      wave_q   <= (fits || !full) ? WAVE_W'(idx_q) : '0;
      opened_q <= !fits && !full;
      ovf_q    <= !fits && full;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign wave_index_o  = wave_q;
  assign opened_wave_o = opened_q;
  assign overflow_o    = ovf_q;

endmodule

`default_nettype wire

[rtl/cfwa_ctrl.sv]
// Controller of the conflict-free wave assigner: takes a request, walks the
// open waves one per cycle and commits the placement. Depends on cfwa_pkg.
`default_nettype none

module cfwa_ctrl
  import cfwa_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire cfwa_sts_t sts_i,
  output cfwa_cmd_t      cmd_o
);

  cfwa_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // A placement is known once a wave fits or the open waves run out.
        if (sts_i.fits || sts_i.at_end) begin
          if (sts_i.out_free) begin
            cmd_o.commit = 1'b1;
            state_d      = ST_IDLE;
          end
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/conflict_free_wave_assigner.sv]
// Conflict-free wave assigner: first-fit placement of tasks into waves.
// A taken request is placed in the first open wave that fits; when the open waves
// run out it opens a new wave, or overflows if all are in use. The scan tests one
// wave per cycle; a new request is taken only after the last one is committed.
// Reset (asynchronous, active low) empties all waves and the response register.
// Depends on cfwa_pkg, cfwa_req_if, cfwa_rsp_if, cfwa_ctrl and cfwa_datapath.
`default_nettype none

module conflict_free_wave_assigner
  import cfwa_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  cfwa_req_if.sink    req_i,
  cfwa_rsp_if.source  rsp_o
);

  cfwa_cmd_t cmd;
  cfwa_sts_t sts;

  // Sequencer for one request at a time.
  cfwa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Wave tables, conflict test and response register.
  cfwa_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .read_mask_i    (req_i.read_mask),
    .write_mask_i   (req_i.write_mask),
    .first_of_set_i (req_i.first_of_set),
    .out_valid_o    (rsp_o.valid),
    .out_ready_i    (rsp_o.ready),
    .wave_index_o   (rsp_o.wave_index),
    .opened_wave_o  (rsp_o.opened_wave),
    .overflow_o     (rsp_o.overflow)
  );

endmodule

`default_nettype wire

[bench/tb_conflict_free_wave_assigner.sv]
// Testbench for the conflict-free wave assigner: random and directed task requests
// checked against a cycle-free first-fit placement predictor.
// Depends on cfwa_pkg, cfwa_req_if, cfwa_rsp_if and conflict_free_wave_assigner.
module tb_conflict_free_wave_assigner
  import cfwa_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                    first_of_set;
    logic [READ_MASK_W-1:0]  read_mask;
    logic [WRITE_MASK_W-1:0] write_mask;
  } wave_task_t;

  typedef struct packed {
    logic [WAVE_W-1:0] wave_index;
    logic              opened_wave;
    logic              overflow;
  } placement_t;

  localparam logic [READ_MASK_W-1:0] LIVE_BITS =
    (MASK_BITS >= READ_MASK_W) ? '1 : READ_MASK_W'((64'd1 << MASK_BITS) - 64'd1);
  localparam int unsigned DIRECTED_ITEMS = 25;
  localparam int unsigned RANDOM_ITEMS   = 1925;
  localparam int unsigned DRAIN_CYCLES   = 2 * (MAX_WAVES + 2);
  localparam int unsigned HOLD_CYCLES    = 400;

  logic clk_i = 1'b0;
  logic rst_ni;

  cfwa_req_if req_if ();
  cfwa_rsp_if rsp_if ();

  conflict_free_wave_assigner i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: per-wave unions of the members' masks and the wave count.
  logic [READ_MASK_W-1:0]  wave_reads  [MAX_WAVES];
  logic [WRITE_MASK_W-1:0] wave_writes [MAX_WAVES];
  logic [CNT_W-1:0]        wave_count;

  wave_task_t  task_q[$];
  placement_t  placement_q[$];

  int unsigned n_queued   = 0;
  int unsigned n_accepted = 0;
  int unsigned n_results  = 0;
  int unsigned n_opened   = 0;
  int unsigned n_overflow = 0;
  int unsigned n_clears   = 0;
  int unsigned mismatches = 0;

  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned phase;
  int unsigned stall_len;
  int unsigned hold_left;
  bit          hold_done;

  // First-fit placement of one task; updates the wave unions as the block does.
  function automatic placement_t place_task(input wave_task_t t);
    placement_t              res;
    logic [READ_MASK_W-1:0]  rd;
    logic [WRITE_MASK_W-1:0] wr;
    int unsigned             n;
    bit                      placed;
    rd = t.read_mask & LIVE_BITS;
    wr = t.write_mask & LIVE_BITS;
    if (t.first_of_set) begin
      for (int w = 0; w < MAX_WAVES; w++) begin
        wave_reads[w]  = '0;
        wave_writes[w] = '0;
      end
      wave_count = '0;
    end
    n = (wave_count > MAX_WAVES) ? MAX_WAVES : wave_count;
    res = '0;
    placed = 1'b0;
    for (int w = 0; w < n && !placed; w++) begin
      if (((wr & wave_writes[w]) | (wr & wave_reads[w]) | (rd & wave_writes[w])) == '0) begin
        wave_reads[w]  |= rd;
        wave_writes[w] |= wr;
        res.wave_index = WAVE_W'(w);
        placed = 1'b1;
      end
    end
    if (!placed) begin
      if (n >= MAX_WAVES) begin
        res.overflow = 1'b1;
      end else begin
        wave_reads[n]   = rd;
        wave_writes[n]  = wr;
        wave_count      = CNT_W'(n + 1);
        res.wave_index  = WAVE_W'(n);
        res.opened_wave = 1'b1;
      end
    end
    return res;
  endfunction

  // A mask with up to three bits set among the lowest span+1 resources.
  function automatic logic [READ_MASK_W-1:0] sparse_mask(input int unsigned span);
    logic [READ_MASK_W-1:0] m;
    m = '0;
    repeat ($urandom_range(0, 3)) m |= READ_MASK_W'(1) << $urandom_range(0, span);
    return m;
  endfunction

  task automatic queue_task(input logic [READ_MASK_W-1:0] rd,
                            input logic [WRITE_MASK_W-1:0] wr, input logic fos);
    wave_task_t t;
    t.read_mask    = rd;
    t.write_mask   = wr;
    t.first_of_set = fos;
    task_q = {task_q, t};
    n_queued++;
  endtask

  task automatic report_field(input string name, input int unsigned want,
                              input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Request driver: bursts of random length separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid        <= 1'b0;
      req_if.read_mask    <= '0;
      req_if.write_mask   <= '0;
      req_if.first_of_set <= 1'b0;
      burst_left          <= 1;
      gap_left            <= 0;
    end else begin : drive_blk
      wave_task_t nxt;
      wave_task_t taken;
      placement_t pred;
      if (req_if.valid && req_if.ready) begin
        taken.read_mask    = req_if.read_mask;
        taken.write_mask   = req_if.write_mask;
        taken.first_of_set = req_if.first_of_set;
        pred = place_task(taken);
        placement_q = {placement_q, pred};
        n_accepted++;
        if (taken.first_of_set) n_clears++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (gap_left != 0) begin
          gap_left     <= gap_left - 1;
          req_if.valid <= 1'b0;
        end else if (task_q.size() != 0) begin
          nxt = task_q.pop_front();
          req_if.valid        <= 1'b1;
          req_if.read_mask    <= nxt.read_mask;
          req_if.write_mask   <= nxt.write_mask;
          req_if.first_of_set <= nxt.first_of_set;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response receiver: periodic stalls of random depth, plus one long hold-off
  // that lets the block back up and stall its request side.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      phase        <= 0;
      stall_len    <= 0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      rsp_if.ready <= (hold_left == 1);
    end else if (!hold_done && n_results >= 150) begin
      hold_left    <= HOLD_CYCLES;
      hold_done    <= 1'b1;
      rsp_if.ready <= 1'b0;
    end else begin
      if (phase == 36) begin
        phase     <= 0;
        stall_len <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
        phase <= phase + 1;
      end
      rsp_if.ready <= (phase >= stall_len) && (stall_len == 0 || $urandom_range(0, 7) != 0);
    end
  end

  // Response monitor: every placement is compared with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin : check_blk
      placement_t want;
      if (placement_q.size() == 0) begin
        $display("%0t: response with no request pending, got wave %0d opened %0b overflow %0b",
                 $time, rsp_if.wave_index, rsp_if.opened_wave, rsp_if.overflow);
        mismatches++;
      end else begin
        want = placement_q.pop_front();
        report_field("wave_index", want.wave_index, rsp_if.wave_index);
        report_field("opened_wave", want.opened_wave, rsp_if.opened_wave);
        report_field("overflow", want.overflow, rsp_if.overflow);
        if (want.opened_wave) n_opened++;
        if (want.overflow) n_overflow++;
      end
      n_results <= n_results + 1;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int unsigned set_len;
    int unsigned span;
    int unsigned hot_bit;
    bit          crowded;
    logic [READ_MASK_W-1:0]  rd;
    logic [WRITE_MASK_W-1:0] wr;

    req_if.valid        = 1'b0;
    req_if.read_mask    = '0;
    req_if.write_mask   = '0;
    req_if.first_of_set = 1'b0;
    rsp_if.ready        = 1'b0;
    rst_ni              = 1'b0;
    for (int w = 0; w < MAX_WAVES; w++) begin
      wave_reads[w]  = '0;
      wave_writes[w] = '0;
    end
    wave_count = '0;

    // Empty tasks, then a write-read overlap and a read-write overlap.
    queue_task('0, '0, 1'b1);
    queue_task('0, '0, 1'b0);
    queue_task(32'h1, '0, 1'b0);
    queue_task('0, 32'h1, 1'b0);
    queue_task('0, 32'h2, 1'b0);
    queue_task(32'h3, '0, 1'b0);
    // A clear with waves open, then every wave filled by mutually conflicting
    // writers, one overflow, an empty task joining wave 0 and a reader that fits nowhere.
    queue_task('1, '1, 1'b1);
    repeat (MAX_WAVES - 1) queue_task('0, '1, 1'b0);
    queue_task('0, '1, 1'b0);
    queue_task('0, '0, 1'b0);
    queue_task(32'h8000_0000, '0, 1'b0);

    // Random sets of tasks; most start with a clear, some are pure noise.
    while (n_queued < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_task($urandom, $urandom, 1'($urandom_range(0, 1)));
      end else begin
        set_len = $urandom_range(1, 40);
        span    = ($urandom_range(0, 1) == 0) ? $urandom_range(3, 7) : $urandom_range(8, 31);
        crowded = ($urandom_range(0, 3) == 0);
        hot_bit = $urandom_range(0, 31);
        for (int i = 0; i < set_len; i++) begin
          rd = sparse_mask(span);
          wr = ($urandom_range(0, 2) == 0) ? '0 : sparse_mask(span);
          if (crowded && $urandom_range(0, 7) != 0) wr |= WRITE_MASK_W'(1) << hot_bit;
          if ($urandom_range(0, 49) == 0) rd = '1;
          queue_task(rd, wr, (i == 0) && ($urandom_range(0, 9) != 0));
        end
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (n_accepted != n_queued || placement_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Checked %0d placements over %0d sets of tasks.", n_results, n_clears);
    $display("Of these, %0d opened a wave and %0d overflowed.", n_opened, n_overflow);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
